// ===== rtl/ccs_pkg.sv =====
`default_nettype none

package ccs_pkg;

  localparam int CHANNELS = 8;
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int LAST_W = 4;
  localparam logic [LAST_W-1:0] CH_LIMIT = LAST_W'(CHANNELS);
  localparam logic [LAST_W-1:0] INVALID_CH = 4'd15;

  localparam int CRC_BYTES = 7;
  localparam int CNT_W = $clog2(CRC_BYTES);
  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_MSB = 8'h80;
  localparam logic [7:0] ERR_MARK = 8'hFF;
  localparam logic [7:0] MANUAL_BASE = 8'd155;
  localparam logic [7:0] PKT_LEN = 8'd8;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_XCHG  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    WO_OK       = 3'd0,
    WO_LENGTH   = 3'd1,
    WO_CRC      = 3'd2,
    WO_CHANNEL  = 3'd3,
    WO_NO_WRITE = 3'd4
  } outcome_t;

  typedef enum logic [1:0] {
    MODE_HYST       = 2'd0,
    MODE_REGULATED  = 2'd1,
    MODE_FIXED_PWR  = 2'd2
  } mode_t;

  localparam logic [0:0] REG_CRC_ERR_STATUS = 1'd0;
  localparam logic [0:0] REG_TIMEOUT_MASK   = 1'd1;

  typedef struct packed {
    logic load;
    logic prep;
    logic crc_step;
    logic exec;
  } cmd_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int j = 0; j < 8; j++) begin
      if ((c & CRC_MSB) != 8'd0) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ccs_ctrl.sv =====
`default_nettype none

module ccs_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  output logic               out_strobe,
  output ccs_pkg::cmd_t      cmd
);
  import ccs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PREP = 5'b00010,
    S_CRC  = 5'b00100,
    S_EXEC = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        cnt_nxt = '0;
        state_nxt = S_CRC;
      end
      S_CRC: begin
        cmd.crc_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(CRC_BYTES - 1)) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign out_strobe = (state_r == S_OUT);

endmodule

`default_nettype wire

// ===== rtl/ccs_datapath.sv =====
`default_nettype none

module ccs_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ccs_pkg::cmd_t       cmd,
  input  wire logic                cfg_we,
  input  wire logic [0:0]          cfg_index,
  input  wire logic [7:0]          cfg_wdata,
  input  wire logic [1:0]          in_op,
  input  wire logic [7:0]          in_write_length,
  input  wire logic [63:0]         in_write_packet,
  input  wire logic [2:0]          in_local_channel,
  input  wire logic [7:0]          in_local_power,
  input  wire logic [7:0]          in_local_status,
  output logic [63:0]              out_response_packet,
  output logic [2:0]               out_write_outcome,
  output logic [1:0]               out_local_mode,
  output logic [6:0]               out_local_manual_power,
  output logic signed [15:0]       out_local_current_temp,
  output logic signed [15:0]       out_local_target_temp
);
  import ccs_pkg::*;

  logic [7:0] crc_err_status_r;
  logic [7:0] timeout_mask_r;
  logic [LAST_W-1:0] last_ch_r;

  logic [1:0]  mode_r   [CHANNELS];
  logic [6:0]  mpow_r   [CHANNELS];
  logic [15:0] cur_r    [CHANNELS];
  logic [15:0] tgt_r    [CHANNELS];
  logic [7:0]  opow_r   [CHANNELS];
  logic [7:0]  status_r [CHANNELS];

  op_t         op_r;
  logic [7:0]  len_r;
  logic [63:0] pkt_r;
  logic [2:0]  lch_r;
  logic [7:0]  lpow_r;
  logic [7:0]  lstat_r;

  logic [55:0] body_r;
  logic [55:0] shift_r;
  logic [7:0]  crc_r;

  logic [63:0] resp_o_r;
  outcome_t    outcome_o_r;
  logic [1:0]  lmode_o_r;
  logic [6:0]  lmpow_o_r;
  logic [15:0] lcur_o_r;
  logic [15:0] ltgt_o_r;

  logic [CH_W-1:0] idx;
  logic [7:0] wr_ch;
  logic [7:0] mode_byte;
  logic [7:0] manual_diff;
  logic lch_ok;
  logic last_ok;
  outcome_t outcome;

  assign wr_ch = pkt_r[55:48];
  assign mode_byte = pkt_r[47:40];
  assign manual_diff = mode_byte - MANUAL_BASE;
  assign lch_ok = ({1'b0, lch_r} < CH_LIMIT);
  assign last_ok = (last_ch_r < CH_LIMIT);

  always_comb begin
    unique case (op_r)
      OP_READ: idx = last_ch_r[CH_W-1:0];
      OP_XCHG: idx = CH_W'({1'b0, lch_r});
      default: idx = wr_ch[CH_W-1:0];
    endcase
  end

  always_comb begin
    priority if (len_r != PKT_LEN) begin
      outcome = WO_LENGTH;
    end else if (crc_r != pkt_r[7:0]) begin
      outcome = WO_CRC;
    end else if (wr_ch >= {4'd0, CH_LIMIT}) begin
      outcome = WO_CHANNEL;
    end else begin
      outcome = WO_OK;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_err_status_r <= 8'd1;
      timeout_mask_r <= 8'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CRC_ERR_STATUS: crc_err_status_r <= cfg_wdata;
        REG_TIMEOUT_MASK:   timeout_mask_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input word and crc unit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= op_t'(in_op);
      len_r <= in_write_length;
      pkt_r <= in_write_packet;
      lch_r <= in_local_channel;
      lpow_r <= in_local_power;
      lstat_r <= in_local_status;
    end
    if (cmd.prep) begin
      crc_r <= 8'd0;
      if (op_r == OP_WRITE) begin
        body_r <= pkt_r[63:8];
        shift_r <= pkt_r[63:8];
      end else if (!last_ok) begin
        body_r <= {ERR_MARK, ERR_MARK, 24'd0, crc_err_status_r, 8'd0};
        shift_r <= {ERR_MARK, ERR_MARK, 24'd0, crc_err_status_r, 8'd0};
      end else begin
        body_r <= {4'd0, last_ch_r, 6'd0, mode_r[idx], opow_r[idx], tgt_r[idx],
                   status_r[idx], 8'd0};
        shift_r <= {4'd0, last_ch_r, 6'd0, mode_r[idx], opow_r[idx], tgt_r[idx],
                    status_r[idx], 8'd0};
      end
    end
    if (cmd.crc_step) begin
      crc_r <= crc8_byte(crc_r, shift_r[55:48]);
      shift_r <= {shift_r[47:0], 8'd0};
    end
  end

  // channel table and last channel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_ch_r <= INVALID_CH;
      for (int i = 0; i < CHANNELS; i++) begin
        mode_r[i] <= MODE_HYST;
        mpow_r[i] <= '0;
        cur_r[i] <= '0;
        tgt_r[i] <= '0;
        opow_r[i] <= '0;
        status_r[i] <= '0;
      end
    end else if (cmd.exec) begin
      if (op_r == OP_WRITE) begin
        if (outcome == WO_OK) begin
          last_ch_r <= wr_ch[LAST_W-1:0];
          if (mode_byte == 8'd0) begin
            mode_r[idx] <= MODE_HYST;
          end else if (mode_byte == 8'd1) begin
            mode_r[idx] <= MODE_REGULATED;
          end else if (mode_byte >= MANUAL_BASE) begin
            mode_r[idx] <= MODE_FIXED_PWR;
            mpow_r[idx] <= manual_diff[6:0];
          end
          cur_r[idx] <= pkt_r[39:24];
          tgt_r[idx] <= pkt_r[23:8];
          status_r[idx] <= status_r[idx] & ~timeout_mask_r;
        end else begin
          last_ch_r <= INVALID_CH;
        end
      end else if (op_r == OP_XCHG && lch_ok) begin
        opow_r[idx] <= lpow_r;
        status_r[idx] <= lstat_r;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      resp_o_r <= '0;
      outcome_o_r <= WO_NO_WRITE;
      lmode_o_r <= '0;
      lmpow_o_r <= '0;
      lcur_o_r <= '0;
      ltgt_o_r <= '0;
      unique case (op_r)
        OP_WRITE: outcome_o_r <= outcome;
        OP_READ:  resp_o_r <= {body_r, crc_r};
        OP_XCHG: begin
          if (lch_ok) begin
            lmode_o_r <= mode_r[idx];
            lmpow_o_r <= mpow_r[idx];
            lcur_o_r <= cur_r[idx];
            ltgt_o_r <= tgt_r[idx];
          end
        end
        default: ;
      endcase
    end
  end

  assign out_response_packet = resp_o_r;
  assign out_write_outcome = outcome_o_r;
  assign out_local_mode = lmode_o_r;
  assign out_local_manual_power = lmpow_o_r;
  assign out_local_current_temp = lcur_o_r;
  assign out_local_target_temp = ltgt_o_r;

endmodule

`default_nettype wire

// ===== rtl/crc_checked_channel_command_slave_core.sv =====
// a new word is accepted only after the previous one is done (busy low); the crc-8 unit is byte-serial (7 steps)
// busy stays high from the accepting edge until the result cycle has ended
// the receiver cannot stall: out_strobe is high for exactly one cycle per word
// synchronous active-low reset clears the controller, the channel table,
// the last channel (invalid) and the configuration registers to their defaults
`default_nettype none

module crc_checked_channel_command_slave_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire logic [1:0]    in_op,
  input  wire logic [7:0]    in_write_length,
  input  wire logic [63:0]   in_write_packet,
  input  wire logic [2:0]    in_local_channel,
  input  wire logic [7:0]    in_local_power,
  input  wire logic [7:0]    in_local_status,
  output logic               out_strobe,
  output logic [63:0]        out_response_packet,
  output logic [2:0]         out_write_outcome,
  output logic [1:0]         out_local_mode,
  output logic [6:0]         out_local_manual_power,
  output logic signed [15:0] out_local_current_temp,
  output logic signed [15:0] out_local_target_temp,
  input  wire logic          cfg_we,
  input  wire logic [0:0]    cfg_index,
  input  wire logic [7:0]    cfg_wdata
);
  import ccs_pkg::*;

  cmd_t cmd;

  ccs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd)
  );

  ccs_datapath u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_op                  (in_op),
    .in_write_length        (in_write_length),
    .in_write_packet        (in_write_packet),
    .in_local_channel       (in_local_channel),
    .in_local_power         (in_local_power),
    .in_local_status        (in_local_status),
    .out_response_packet    (out_response_packet),
    .out_write_outcome      (out_write_outcome),
    .out_local_mode         (out_local_mode),
    .out_local_manual_power (out_local_manual_power),
    .out_local_current_temp (out_local_current_temp),
    .out_local_target_temp  (out_local_target_temp)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe && !busy)
    else $error("result strobe longer than one cycle");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result strobe outside a busy period");

  a_write_no_resp: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_write_outcome != WO_NO_WRITE) |-> (out_response_packet == 64'd0))
    else $error("write result carries a response packet");

endmodule

`default_nettype wire

// ===== tb/crc_checked_channel_command_slave_core_tb.sv =====
`timescale 1ns / 100ps

module crc_checked_channel_command_slave_core_tb;
  import ccs_pkg::*;

  localparam int CLK_HALF = 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 14;
  localparam int ITEMS_PER_PHASE = 150;

  typedef struct {
    op_t         op;
    logic [7:0]  length;
    logic [63:0] packet;
    logic [2:0]  channel;
    logic [7:0]  power;
    logic [7:0]  status;
  } command_t;

  typedef struct {
    logic [63:0]        packet;
    logic [2:0]         outcome;
    logic [1:0]         mode;
    logic [6:0]         manual_power;
    logic signed [15:0] current_temp;
    logic signed [15:0] target_temp;
  } reply_t;

  class heater_reply_tracker;
    logic [7:0]  err_status;
    logic [7:0]  timeout_mask;
    logic [3:0]  last_ch;
    mode_t       ch_mode [CHANNELS];
    logic [6:0]  man_power [CHANNELS];
    logic [15:0] cur_temp [CHANNELS];
    logic [15:0] tgt_temp [CHANNELS];
    logic [7:0]  out_power [CHANNELS];
    logic [7:0]  ch_status [CHANNELS];
    reply_t      pending_replies [$];
    int          mismatches;

    function new();
      err_status = 8'd1;
      timeout_mask = 8'd2;
      last_ch = INVALID_CH;
      mismatches = 0;
      for (int c = 0; c < CHANNELS; c++) begin
        ch_mode[c] = MODE_HYST;
        man_power[c] = '0;
        cur_temp[c] = '0;
        tgt_temp[c] = '0;
        out_power[c] = '0;
        ch_status[c] = '0;
      end
    endfunction

    // bit-serial crc-8 over bytes 0..6, msb first
    static function logic [7:0] seven_byte_crc(logic [63:0] p);
      logic [7:0] crc;
      logic       fb;
      crc = '0;
      for (int i = 63; i >= 8; i--) begin
        fb = crc[7] ^ p[i];
        crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      end
      return crc;
    endfunction

    function void set_register(logic [0:0] idx, logic [7:0] value);
      if (idx == REG_CRC_ERR_STATUS) begin
        err_status = value;
      end else begin
        timeout_mask = value;
      end
    endfunction

    function void note_command(command_t c);
      reply_t      r;
      logic [63:0] p;
      logic [7:0]  ch_byte;
      logic [7:0]  mb;
      int          ch;
      r = '{packet: '0, outcome: WO_NO_WRITE, mode: '0, manual_power: '0,
            current_temp: '0, target_temp: '0};
      p = c.packet;
      case (c.op)
        OP_WRITE: begin
          ch_byte = p[55:48];
          if (c.length != PKT_LEN) begin
            last_ch = INVALID_CH;
            r.outcome = WO_LENGTH;
          end else if (seven_byte_crc(p) != p[7:0]) begin
            last_ch = INVALID_CH;
            r.outcome = WO_CRC;
          end else if (ch_byte >= CHANNELS) begin
            last_ch = INVALID_CH;
            r.outcome = WO_CHANNEL;
          end else begin
            ch = ch_byte;
            last_ch = ch_byte[3:0];
            mb = p[47:40];
            if (mb == 8'd0) begin
              ch_mode[ch] = MODE_HYST;
            end else if (mb == 8'd1) begin
              ch_mode[ch] = MODE_REGULATED;
            end else if (mb >= MANUAL_BASE) begin
              ch_mode[ch] = MODE_FIXED_PWR;
              man_power[ch] = 7'(mb - MANUAL_BASE);
            end
            cur_temp[ch] = p[39:24];
            tgt_temp[ch] = p[23:8];
            ch_status[ch] = ch_status[ch] & ~timeout_mask;
            r.outcome = WO_OK;
          end
        end
        OP_READ: begin
          if (last_ch >= CH_LIMIT) begin
            p = {ERR_MARK, ERR_MARK, 24'h0, err_status, 16'h0};
          end else begin
            ch = last_ch;
            p = {4'h0, last_ch, 6'h0, ch_mode[ch], out_power[ch], tgt_temp[ch],
                 ch_status[ch], 16'h0};
          end
          p[7:0] = seven_byte_crc(p);
          r.packet = p;
        end
        OP_XCHG: begin
          ch = c.channel;
          if (ch < CHANNELS) begin
            out_power[ch] = c.power;
            ch_status[ch] = c.status;
            r.mode = ch_mode[ch];
            r.manual_power = man_power[ch];
            r.current_temp = cur_temp[ch];
            r.target_temp = tgt_temp[ch];
          end
        end
        default: begin
        end
      endcase
      pending_replies.push_back(r);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected word: pkt=%h outcome=%0d", got.packet, got.outcome);
        end
        return;
      end
      want = pending_replies.pop_front();
      if (got.packet !== want.packet || got.outcome !== want.outcome ||
          got.mode !== want.mode || got.manual_power !== want.manual_power ||
          got.current_temp !== want.current_temp || got.target_temp !== want.target_temp) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected pkt=%h outcome=%0d mode=%0d mpow=%0d cur=%0d tgt=%0d",
                   want.packet, want.outcome, want.mode, want.manual_power,
                   want.current_temp, want.target_temp);
          $display("          actual   pkt=%h outcome=%0d mode=%0d mpow=%0d cur=%0d tgt=%0d",
                   got.packet, got.outcome, got.mode, got.manual_power,
                   got.current_temp, got.target_temp);
        end
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_op = '0;
  logic [7:0]         in_write_length = '0;
  logic [63:0]        in_write_packet = '0;
  logic [2:0]         in_local_channel = '0;
  logic [7:0]         in_local_power = '0;
  logic [7:0]         in_local_status = '0;
  logic               out_strobe;
  logic [63:0]        out_response_packet;
  logic [2:0]         out_write_outcome;
  logic [1:0]         out_local_mode;
  logic [6:0]         out_local_manual_power;
  logic signed [15:0] out_local_current_temp;
  logic signed [15:0] out_local_target_temp;
  logic               cfg_we = 1'b0;
  logic [0:0]         cfg_index = '0;
  logic [7:0]         cfg_wdata = '0;

  heater_reply_tracker tracker;
  reply_t              seen_reply;
  int                  cycle_count = 0;
  bit                  no_idle = 1'b0;
  int                  burst_left = 0;

  crc_checked_channel_command_slave_core i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_op                  (in_op),
    .in_write_length        (in_write_length),
    .in_write_packet        (in_write_packet),
    .in_local_channel       (in_local_channel),
    .in_local_power         (in_local_power),
    .in_local_status        (in_local_status),
    .out_strobe             (out_strobe),
    .out_response_packet    (out_response_packet),
    .out_write_outcome      (out_write_outcome),
    .out_local_mode         (out_local_mode),
    .out_local_manual_power (out_local_manual_power),
    .out_local_current_temp (out_local_current_temp),
    .out_local_target_temp  (out_local_target_temp),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata)
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      seen_reply.packet = out_response_packet;
      seen_reply.outcome = out_write_outcome;
      seen_reply.mode = out_local_mode;
      seen_reply.manual_power = out_local_manual_power;
      seen_reply.current_temp = out_local_current_temp;
      seen_reply.target_temp = out_local_target_temp;
      tracker.check_reply(seen_reply);
    end
  end

  function automatic command_t noise_command();
    command_t c;
    c.op = op_t'($urandom_range(0, 3));
    c.length = 8'($urandom);
    c.packet = {$urandom, $urandom};
    c.channel = 3'($urandom);
    c.power = 8'($urandom);
    c.status = 8'($urandom);
    return c;
  endfunction

  function automatic command_t write_word(logic [7:0] ch, logic [7:0] mode_byte,
                                          logic [15:0] cur, logic [15:0] tgt);
    command_t c;
    c = noise_command();
    c.op = OP_WRITE;
    c.length = PKT_LEN;
    c.packet = {8'($urandom), ch, mode_byte, cur, tgt, 8'h00};
    c.packet[7:0] = heater_reply_tracker::seven_byte_crc(c.packet);
    return c;
  endfunction

  function automatic command_t simple_command(op_t op);
    command_t c;
    c = noise_command();
    c.op = op;
    return c;
  endfunction

  function automatic command_t xchg_word(logic [2:0] ch, logic [7:0] pw, logic [7:0] st);
    command_t c;
    c = simple_command(OP_XCHG);
    c.channel = ch;
    c.power = pw;
    c.status = st;
    return c;
  endfunction

  task automatic issue(input command_t c);
    int gap;
    if (burst_left == 0) begin
      no_idle = ($urandom_range(0, 3) == 0);
      burst_left = $urandom_range(8, 40);
    end
    burst_left--;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_op <= c.op;
    in_write_length <= c.length;
    in_write_packet <= c.packet;
    in_local_channel <= c.channel;
    in_local_power <= c.power;
    in_local_status <= c.status;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    tracker.note_command(c);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (tracker.pending_replies.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // cfg_we is left high; the caller drops it after its last write
  task automatic write_reg(input logic [0:0] idx, input logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    tracker.set_register(idx, value);
  endtask

  function automatic command_t random_command();
    command_t c;
    int       pick;
    int       kind;
    logic [7:0] ch;
    logic [7:0] mb;
    pick = $urandom_range(0, 99);
    if (pick < 42) begin
      ch = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, CHANNELS - 1));
      kind = $urandom_range(0, 4);
      case (kind)
        0: mb = 8'd0;
        1: mb = 8'd1;
        2: mb = 8'($urandom_range(155, 255));
        3: mb = 8'($urandom_range(2, 154));
        default: mb = 8'($urandom);
      endcase
      c = write_word(ch, mb, 16'($urandom), 16'($urandom));
    end else if (pick < 52) begin
      kind = $urandom_range(0, 2);
      c = write_word(8'($urandom_range(0, CHANNELS - 1)), 8'($urandom),
                     16'($urandom), 16'($urandom));
      if (kind == 0) begin
        c.length = 8'($urandom);
      end else if (kind == 1) begin
        c.packet[7:0] = c.packet[7:0] ^ 8'($urandom_range(1, 255));
      end else begin
        c.packet = {$urandom, $urandom};
      end
    end else if (pick < 74) begin
      c = simple_command(OP_READ);
    end else if (pick < 96) begin
      c = simple_command(OP_XCHG);
    end else begin
      c = simple_command(OP_NONE);
    end
    return c;
  endfunction

  initial begin
    command_t c;
    tracker = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset state: error packet, zero settings
    issue(simple_command(OP_READ));
    issue(xchg_word(3'd0, 8'hFF, 8'hFF));
    issue(write_word(8'd0, 8'd0, 16'h8000, 16'h7FFF));
    issue(simple_command(OP_READ));
    issue(xchg_word(3'd7, 8'hA5, 8'hFF));
    issue(write_word(8'd7, 8'd1, 16'hFFFF, 16'h0000));
    issue(simple_command(OP_READ));
    issue(write_word(8'd7, 8'd155, 16'h0001, 16'hFFFF));
    issue(write_word(8'd7, 8'd255, 16'h7FFF, 16'h8000));
    // unknown mode bytes keep mode and power
    issue(write_word(8'd7, 8'd2, 16'h1234, 16'h5678));
    issue(write_word(8'd7, 8'd154, 16'hABCD, 16'hEF01));
    issue(xchg_word(3'd7, 8'h00, 8'h00));
    issue(simple_command(OP_READ));
    // length errors, packet ignored
    c = write_word(8'd0, 8'd1, 16'h0, 16'h0);
    c.length = 8'd0;
    issue(c);
    c.length = 8'd255;
    c.packet = '1;
    issue(c);
    c = write_word(8'd0, 8'd1, 16'h0, 16'h0);
    c.length = 8'd7;
    issue(c);
    issue(simple_command(OP_READ));
    issue(write_word(8'd3, 8'd200, 16'h0102, 16'h0304));
    c = write_word(8'd3, 8'd1, 16'h0, 16'h0);
    c.packet[7:0] = ~c.packet[7:0];
    issue(c);
    issue(simple_command(OP_READ));
    issue(write_word(8'd8, 8'd1, 16'h0, 16'h0));
    issue(write_word(8'd255, 8'd0, 16'h0, 16'h0));
    issue(simple_command(OP_READ));
    c = noise_command();
    c.op = OP_NONE;
    c.length = '1;
    c.packet = '1;
    c.channel = '1;
    c.power = '1;
    c.status = '1;
    issue(c);
    issue(xchg_word(3'd3, 8'h55, 8'hAA));

    for (int phase = 0; phase < 4; phase++) begin
      drain();
      case (phase)
        0: begin
          write_reg(REG_CRC_ERR_STATUS, 8'h00);
          write_reg(REG_TIMEOUT_MASK, 8'h00);
        end
        1: begin
          write_reg(REG_CRC_ERR_STATUS, 8'hFF);
          write_reg(REG_TIMEOUT_MASK, 8'hFF);
        end
        2: begin
          write_reg(REG_CRC_ERR_STATUS, 8'($urandom));
          write_reg(REG_TIMEOUT_MASK, 8'($urandom));
        end
        default: begin
          write_reg(REG_CRC_ERR_STATUS, 8'd1);
          write_reg(REG_TIMEOUT_MASK, 8'd2);
        end
      endcase
      cfg_we <= 1'b0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        issue(random_command());
      end
    end

    drain();
    if (tracker.mismatches == 0 && tracker.pending_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
